// ----- hw/rtl/chunked_body_decoder_defines.svh -----
// Assertion macros for the chunked body decoder.
// Used by chunked_body_decoder.sv; depends on nothing else.
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cbd_pkg.sv -----
// Shared types, codes and character constants for the chunked body decoder.
// Used by chunked_body_decoder.sv; depends on nothing else.
package cbd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  typedef enum logic [2:0] {
    MODE_LEAD    = 3'd0,
    MODE_NUMBER  = 3'd1,
    MODE_REST    = 3'd2,
    MODE_DATA    = 3'd3,
    MODE_TRAILER = 3'd4,
    MODE_DONE    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_ZERO  = 2'd1,
    ST_CLEAN = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Sub-phase of the size number.
  localparam logic [1:0] DC_SIGN   = 2'd0;
  localparam logic [1:0] DC_ZERO   = 2'd1;
  localparam logic [1:0] DC_PREFIX = 2'd2;
  localparam logic [1:0] DC_DIGITS = 2'd3;

  localparam logic [1:0] TRAILER_BYTES = 2'd2;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_   = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } body_req_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       chunk_first;
    logic [1:0] end_status;
  } result_t;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] v;
    v = 8'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      v = b - CH_ZERO;
      return {1'b1, v[3:0]};
    end else if (b >= CH_LA && b <= CH_LF_) begin
      v = b - CH_LA + 8'd10;
      return {1'b1, v[3:0]};
    end else if (b >= CH_UA && b <= CH_UF) begin
      v = b - CH_UA + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ----- hw/rtl/chunked_body_decoder.sv -----
// Chunked body decoder top level: size-line parser, chunk counter, result buffer.
// Depends on cbd_pkg and chunked_body_decoder_defines.svh.
//
// Takes one body byte per request and takes a new request in every cycle: all the
// work for a byte is one registered pass through the size-line parser and the
// chunk byte counter. Results (payload bytes and end markers) go into a two-entry
// output buffer, so intake stalls only when both entries are full. A request whose
// result is produced is registered onto the result port when the output entry is
// free or being taken; otherwise it waits in the buffer.
// After a final byte all parse state returns to its reset values.
`include "chunked_body_decoder_defines.svh"

module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      body_valid,
  output logic      body_ready,
  input  body_req_t body,
  output logic      result_valid,
  input  logic      result_ready,
  output result_t   result
);

  mode_t                  mode, mode_next;
  logic [LENGTH_BITS-1:0] length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic                   negative_seen, negative_seen_next;
  logic [1:0]             digit_count, digit_count_next;
  logic                   saw_cr, saw_cr_next;
  logic [1:0]             trailer_left, trailer_left_next;

  status_t                stop_status;
  status_t                end_code;
  logic                   swallow;
  logic                   pay;
  logic                   produce;
  logic                   body_fire;
  logic [7:0]             b;
  logic [4:0]             hex;
  logic                   overflow;
  result_t                result_new;

  logic                   skid_valid;
  result_t                skid;

  assign b         = body.data_byte;
  assign hex       = hex_digit(b);
  assign body_fire = body_valid && body_ready;
  // A further digit would not fit when any of the top four bits is already set.
  assign overflow  = |length_accum[LENGTH_BITS-1 -: 4];

  // Next state of the parser.
  always_comb begin
    mode_next          = mode;
    length_accum_next  = length_accum;
    bytes_left_next    = bytes_left;
    negative_seen_next = negative_seen;
    digit_count_next   = digit_count;
    saw_cr_next        = saw_cr;
    trailer_left_next  = trailer_left;
    stop_status        = ST_RUN;
    swallow            = 1'b0;

    unique case (mode)
      MODE_LEAD: begin
        if (b == CH_SP || b == CH_TAB) begin
          mode_next = MODE_LEAD;
        end else if (b == CH_PLUS || b == CH_MINUS) begin
          negative_seen_next = (b == CH_MINUS);
          digit_count_next   = DC_SIGN;
          mode_next          = MODE_NUMBER;
        end else if (b == CH_ZERO) begin
          digit_count_next = DC_ZERO;
          mode_next        = MODE_NUMBER;
        end else if (hex[4]) begin
          mode_next = MODE_NUMBER;
          if (overflow) begin
            length_accum_next = '1;
            stop_status       = ST_BAD;
          end else begin
            length_accum_next = {length_accum[LENGTH_BITS-5:0], hex[3:0]};
            digit_count_next  = DC_DIGITS;
          end
        end else begin
          mode_next   = MODE_REST;
          saw_cr_next = (b == CH_CR);
        end
      end
      MODE_NUMBER: begin
        if (digit_count == DC_ZERO && (b == CH_X_LO || b == CH_X_UP)) begin
          digit_count_next = DC_PREFIX;
        end else if (digit_count == DC_SIGN && b == CH_ZERO) begin
          digit_count_next = DC_ZERO;
        end else if (hex[4]) begin
          if (overflow) begin
            length_accum_next = '1;
            stop_status       = ST_BAD;
          end else begin
            length_accum_next = {length_accum[LENGTH_BITS-5:0], hex[3:0]};
            digit_count_next  = DC_DIGITS;
          end
        end else begin
          mode_next   = MODE_REST;
          saw_cr_next = (b == CH_CR);
        end
      end
      MODE_REST: begin
        if (saw_cr && b == CH_LF) begin
          if (negative_seen || length_accum == '0) begin
            stop_status = ST_ZERO;
          end else begin
            bytes_left_next = length_accum;
            mode_next       = MODE_DATA;
          end
          saw_cr_next = 1'b0;
        end else begin
          saw_cr_next = (b == CH_CR);
        end
      end
      MODE_DATA: begin
        bytes_left_next = bytes_left - LENGTH_BITS'(1);
        if (bytes_left == LENGTH_BITS'(1)) begin
          mode_next         = MODE_TRAILER;
          trailer_left_next = TRAILER_BYTES;
        end
      end
      MODE_TRAILER: begin
        if (trailer_left <= 2'd1) begin
          // Trailer done: start the next size line.
          mode_next          = MODE_LEAD;
          length_accum_next  = '0;
          bytes_left_next    = '0;
          negative_seen_next = 1'b0;
          digit_count_next   = DC_SIGN;
          saw_cr_next        = 1'b0;
          trailer_left_next  = 2'd0;
        end else begin
          trailer_left_next = trailer_left - 2'd1;
        end
      end
      default: begin
        mode_next = MODE_DONE;
        swallow   = 1'b1;
      end
    endcase

    if (stop_status != ST_RUN) begin
      mode_next = MODE_DONE;
    end
  end

  // Result for the byte being accepted.
  always_comb begin
    pay = (mode == MODE_DATA);
    if (stop_status != ST_RUN) begin
      end_code = stop_status;
    end else if (body.final_byte) begin
      end_code = (mode_next == MODE_DATA) ? ST_BAD : ST_CLEAN;
    end else begin
      end_code = ST_RUN;
    end
    produce                 = body_fire && !swallow && (pay || end_code != ST_RUN);
    result_new.payload_byte = pay ? b : 8'd0;
    result_new.has_payload  = pay;
    result_new.chunk_first  = pay && (bytes_left == length_accum);
    result_new.end_status   = end_code;
  end

  always_ff @(posedge clk) begin
    if (rst || (body_fire && body.final_byte)) begin
      mode          <= MODE_LEAD;
      length_accum  <= '0;
      bytes_left    <= '0;
      negative_seen <= 1'b0;
      digit_count   <= DC_SIGN;
      saw_cr        <= 1'b0;
      trailer_left  <= 2'd0;
    end else if (body_fire) begin
      mode          <= mode_next;
      length_accum  <= length_accum_next;
      bytes_left    <= bytes_left_next;
      negative_seen <= negative_seen_next;
      digit_count   <= digit_count_next;
      saw_cr        <= saw_cr_next;
      trailer_left  <= trailer_left_next;
    end
  end

  // Two-entry result buffer: the skid entry catches a result while the output waits.
  assign body_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result <= skid;
      end else if (produce) begin
        result <= result_new;
      end
    end else if (produce) begin
      skid <= result_new;
    end
  end

  `CBD_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, result_valid,
                  "skid full while output empty")
  `CBD_ASSERT_NOW(a_data_owed, clk, rst, mode == MODE_DATA, bytes_left != '0,
                  "data mode with no bytes owed")
  `CBD_ASSERT_NOW(a_payload_status, clk, rst, produce && result_new.has_payload,
                  result_new.end_status != ST_ZERO, "payload with zero-size status")
  `CBD_ASSERT_NEXT(a_final_restarts, clk, rst, body_fire && body.final_byte,
                   mode == MODE_LEAD && length_accum == '0, "final byte did not restart parser")

endmodule

// ----- bench/chunked_body_decoder_test.sv -----
// Self-checking testbench for chunked_body_decoder: a short directed script, then random
// chunked bodies, checked byte by byte against a predictor of the size-line parser.
// Depends on cbd_pkg and the decoder RTL; needs no other file.
module chunked_body_decoder_test;
  import cbd_pkg::*;

  localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int SCRIPT_ROWS = 27;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    body_req_t req;
    logic      known;
    result_t   want;
  } script_row_t;

  // Directed script. Rows with known set carry a result that is plain from the bytes;
  // the rest are checked against the predictor.
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{'{CH_SP,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_TAB,   1'b0}, 1'b0, NO_RESULT},
    '{'{CH_PLUS,  1'b0}, 1'b0, NO_RESULT},
    '{'{CH_ZERO,  1'b0}, 1'b0, NO_RESULT},
    '{'{CH_X_UP,  1'b0}, 1'b0, NO_RESULT},
    '{'{8'h32,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_SEMI,  1'b0}, 1'b0, NO_RESULT},
    '{'{CH_CR,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_LF,    1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00,    1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, ST_RUN}},
    '{'{8'hFF,    1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, ST_RUN}},
    '{'{CH_CR,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_LF,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_CR,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_LF,    1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, ST_ZERO}},
    '{'{8'h47,    1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF,    1'b1}, 1'b0, NO_RESULT},
    '{'{CH_MINUS, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h33,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_CR,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_LF,    1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, ST_ZERO}},
    '{'{8'h80,    1'b1}, 1'b0, NO_RESULT},
    '{'{CH_LA,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_CR,    1'b0}, 1'b0, NO_RESULT},
    '{'{CH_LF,    1'b0}, 1'b0, NO_RESULT},
    '{'{8'h5A,    1'b1}, 1'b1, '{8'h5A, 1'b1, 1'b1, ST_BAD}},
    '{'{CH_SP,    1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, ST_CLEAN}}
  };

  logic      clk;
  logic      rst = 1'b1;
  logic      body_valid = 1'b0;
  logic      body_ready;
  body_req_t body = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  result_t   result;

  // Predictor state for the size-line parser and chunk counter.
  mode_t       size_mode;
  logic [63:0] size_accum;
  logic [63:0] bytes_owed;
  logic        size_negative;
  logic [1:0]  number_phase;
  logic        cr_pending;
  logic [1:0]  trailer_count;

  result_t     owed_results[$];
  logic [7:0]  body_text[$];
  int          mismatches = 0;
  int          fed_bytes = 0;
  int unsigned stall_left = 0;
  bit          calm_stretch = 1'b0;
  bit          hold_results = 1'b0;
  bit          random_phase = 1'b0;

  chunked_body_decoder uut (
    .clk,
    .rst,
    .body_valid,
    .body_ready,
    .body,
    .result_valid,
    .result_ready,
    .result
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Quiet stretches with no idling alternate with stretches of random gaps.
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm_stretch <= ~calm_stretch;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm_stretch || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int unsigned pick_size();
    if ($urandom_range(99) < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 64);
  endfunction

  // Returns {is_hex, value}; letters of either case share the low nibble of their code.
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return {1'b1, b[3:0]};
    if ((b >= CH_UA && b <= CH_UF) || (b >= CH_LA && b <= CH_LF_)) return {1'b1, b[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
    return (upper ? CH_UA : CH_LA) + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void clear_size_line();
    size_mode = MODE_LEAD;
    size_accum = 64'd0;
    bytes_owed = 64'd0;
    size_negative = 1'b0;
    number_phase = DC_SIGN;
    cr_pending = 1'b0;
    trailer_count = 2'd0;
  endfunction

  // Shifts in one digit; on overflow the length saturates and 0 is returned.
  function automatic bit take_digit(input logic [3:0] nib);
    if (size_accum > (LEN_MAX >> 4)) begin
      size_accum = LEN_MAX;
      return 1'b0;
    end
    size_accum = {size_accum[59:0], nib};
    number_phase = DC_DIGITS;
    return 1'b1;
  endfunction

  task automatic decode_step(input body_req_t req, output bit produced, output result_t res);
    logic [7:0] b;
    logic [4:0] nib;
    status_t    status;
    bit         pay, first, ignored;
    b = req.data_byte;
    nib = nibble_of(b);
    status = ST_RUN;
    pay = 1'b0;
    first = 1'b0;
    ignored = 1'b0;
    case (size_mode)
      MODE_LEAD: begin
        if (b != CH_SP && b != CH_TAB) begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            size_negative = (b == CH_MINUS);
            number_phase = DC_SIGN;
            size_mode = MODE_NUMBER;
          end else if (b == CH_ZERO) begin
            number_phase = DC_ZERO;
            size_mode = MODE_NUMBER;
          end else if (nib[4]) begin
            size_mode = MODE_NUMBER;
            if (!take_digit(nib[3:0])) status = ST_BAD;
          end else begin
            size_mode = MODE_REST;
            cr_pending = (b == CH_CR);
          end
        end
      end
      MODE_NUMBER: begin
        if (number_phase == DC_ZERO && (b == CH_X_LO || b == CH_X_UP)) begin
          number_phase = DC_PREFIX;
        end else if (number_phase == DC_SIGN && b == CH_ZERO) begin
          number_phase = DC_ZERO;
        end else if (nib[4]) begin
          if (!take_digit(nib[3:0])) status = ST_BAD;
        end else begin
          size_mode = MODE_REST;
          cr_pending = (b == CH_CR);
        end
      end
      MODE_REST: begin
        if (cr_pending && b == CH_LF) begin
          if (size_negative || size_accum == 64'd0) begin
            status = ST_ZERO;
          end else begin
            bytes_owed = size_accum;
            size_mode = MODE_DATA;
          end
          cr_pending = 1'b0;
        end else begin
          cr_pending = (b == CH_CR);
        end
      end
      MODE_DATA: begin
        pay = 1'b1;
        first = (bytes_owed == size_accum);
        if (bytes_owed != 64'd0) bytes_owed = bytes_owed - 64'd1;
        if (bytes_owed == 64'd0) begin
          size_mode = MODE_TRAILER;
          trailer_count = TRAILER_BYTES;
        end
      end
      MODE_TRAILER: begin
        if (trailer_count != 2'd0) trailer_count = trailer_count - 2'd1;
        if (trailer_count == 2'd0) clear_size_line();
      end
      default: begin
        // After an end marker everything is swallowed up to the final byte.
        size_mode = MODE_DONE;
        ignored = 1'b1;
      end
    endcase
    if (!ignored) begin
      if (status != ST_RUN) size_mode = MODE_DONE;
      else if (req.final_byte) status = (size_mode == MODE_DATA) ? ST_BAD : ST_CLEAN;
    end
    if (req.final_byte) clear_size_line();
    produced = !ignored && (pay || status != ST_RUN);
    res.payload_byte = pay ? b : 8'h00;
    res.has_payload = pay;
    res.chunk_first = first;
    res.end_status = status;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
    end else begin
      want = owed_results.pop_front();
      if (got.payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %h, expected %h", got.payload_byte,
                                  want.payload_byte));
      if (got.has_payload !== want.has_payload)
        report_mismatch($sformatf("has_payload %b, expected %b", got.has_payload,
                                  want.has_payload));
      if (got.chunk_first !== want.chunk_first)
        report_mismatch($sformatf("chunk_first %b, expected %b", got.chunk_first,
                                  want.chunk_first));
      if (got.end_status !== want.end_status)
        report_mismatch($sformatf("end_status %0d, expected %0d", got.end_status,
                                  want.end_status));
    end
  endtask

  // Valid goes low only for a gap, so it is never lowered and raised in one step.
  task automatic offer_request(input body_req_t req, input bit known, input result_t want);
    int unsigned idle;
    bit          produced;
    result_t     predicted;
    idle = pick_gap();
    if (idle != 0) begin
      body_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    body_valid <= 1'b1;
    body <= req;
    do @(posedge clk); while (!body_ready);
    if (size_mode != MODE_DONE) fed_bytes++;
    decode_step(req, produced, predicted);
    if (known) owed_results.push_back(want);
    else if (produced) owed_results.push_back(predicted);
  endtask

  task automatic put_size_line(input logic [63:0] value, input bit negative);
    int unsigned style;
    bit          upper, started;
    logic [7:0]  junk;
    style = $urandom_range(99);
    upper = 1'($urandom_range(1));
    started = 1'b0;
    if (style < 20) begin
      repeat ($urandom_range(1, 3)) body_text.push_back($urandom_range(1) ? CH_SP : CH_TAB);
    end
    if (negative) body_text.push_back(CH_MINUS);
    else if (style % 10 == 3) body_text.push_back(CH_PLUS);
    if (style % 7 == 0) begin
      body_text.push_back(CH_ZERO);
      body_text.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
    end else if (style % 5 == 1) begin
      body_text.push_back(CH_ZERO);
    end
    for (int i = 15; i >= 0; i--) begin
      if (started || value[i*4 +: 4] != 4'd0 || i == 0) begin
        started = 1'b1;
        body_text.push_back(hex_char(value[i*4 +: 4], upper));
      end
    end
    // Extension text up to the CR LF is ignored by the parser.
    if (style % 6 == 2) begin
      body_text.push_back(CH_SEMI);
      repeat ($urandom_range(0, 5)) begin
        junk = 8'($urandom_range(255));
        body_text.push_back(junk == CH_CR ? CH_SP : junk);
      end
    end
    body_text.push_back(CH_CR);
    body_text.push_back(CH_LF);
  endtask

  // Mostly well-formed bodies with random content, mixed with broken and truncated ones.
  task automatic build_body();
    int unsigned shape, size, ending;
    body_text.delete();
    shape = $urandom_range(99);
    if (shape < 6) begin
      repeat ($urandom_range(1, 12)) body_text.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        size = pick_size();
        put_size_line(64'(size), 1'b0);
        repeat (size) body_text.push_back(8'($urandom_range(255)));
        if ($urandom_range(99) < 85) begin
          body_text.push_back(CH_CR);
          body_text.push_back(CH_LF);
        end else begin
          repeat (2) body_text.push_back(8'($urandom_range(255)));
        end
      end
      ending = $urandom_range(9);
      if (shape < 70) begin
        case (ending)
          5: put_size_line(64'($urandom_range(1, 300)), 1'b1);
          6: begin
            body_text.push_back(CH_PLUS);
            body_text.push_back(CH_CR);
            body_text.push_back(CH_LF);
          end
          7: begin
            body_text.push_back(CH_ZERO);
            body_text.push_back(CH_X_LO);
            body_text.push_back(CH_CR);
            body_text.push_back(CH_LF);
          end
          8: begin
            body_text.push_back(CH_CR);
            body_text.push_back(CH_LF);
          end
          9: put_size_line(64'd0, 1'b1);
          default: put_size_line(64'd0, 1'b0);
        endcase
        if ($urandom_range(3) != 0) begin
          body_text.push_back(CH_CR);
          body_text.push_back(CH_LF);
        end
      end else if (shape < 78) begin
        // Nine or more significant digits overflow the length.
        if ($urandom_range(1) != 0) body_text.push_back(CH_SP);
        body_text.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
        repeat ($urandom_range(8, 11))
          body_text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        if ($urandom_range(1) != 0) begin
          body_text.push_back(CH_CR);
          body_text.push_back(CH_LF);
        end
      end else if (shape < 88) begin
        size = $urandom_range(1, 24);
        put_size_line(64'(size), 1'b0);
        repeat ($urandom_range(0, size - 1)) body_text.push_back(8'($urandom_range(255)));
      end else if (shape < 92) begin
        put_size_line(LEN_MAX, 1'b0);
        repeat ($urandom_range(1, 6)) body_text.push_back(8'($urandom_range(255)));
      end else begin
        size = pick_size();
        put_size_line(64'(size), 1'b0);
        repeat (size) body_text.push_back(8'($urandom_range(255)));
        if (ending > 6) begin
          body_text.push_back(CH_CR);
        end else if (ending > 3) begin
          body_text.push_back(CH_CR);
          body_text.push_back(CH_LF);
          body_text.push_back(CH_SP);
          body_text.push_back(hex_char(4'($urandom_range(1, 15)), 1'b0));
        end
      end
    end
  endtask

  // Result side: checks every accepted result and stalls at random.
  always @(posedge clk) begin
    int unsigned pause;
    if (!rst && result_valid && result_ready) check_result(result);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (hold_results) begin
      result_ready <= 1'b0;
    end else begin
      pause = pick_gap();
      result_ready <= (pause == 0);
      stall_left <= pause;
    end
  end

  // Long hold-off on the result side so the output buffer fills and stalls intake.
  initial begin
    wait (random_phase);
    repeat ($urandom_range(50, 300)) @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin
    body_req_t req;
    clear_size_line();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      offer_request(SCRIPT[r].req, SCRIPT[r].known, SCRIPT[r].want);
    end
    random_phase = 1'b1;
    fed_bytes = 0;
    while (fed_bytes < RANDOM_ITEMS) begin
      build_body();
      foreach (body_text[i]) begin
        req.data_byte = body_text[i];
        req.final_byte = (i == body_text.size() - 1);
        offer_request(req, 1'b0, NO_RESULT);
      end
    end
    body_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
